// ===== hdl/fvn_pkg.sv =====
// Shared constants, codes and the cosine blend table builder for fractal value noise.
package fvn_pkg;

  // Pipeline shape
  localparam int OCT_STAGES = 10;   // stages inside one octave lane
  localparam int QUO_W      = 31;   // quotient magnitude bits, |result| <= 2^30
  localparam int AMP_W      = 17;   // octave amplitude, Q1.16 with 1.0 = 65536
  localparam int WGT_W      = 49;   // octave value times amplitude
  localparam int WT_W       = 31;   // blend weight, Q1.30 up to 1.0

  localparam logic [AMP_W-1:0] AMP_ONE = 17'h1_0000;

  // Lattice hash constants
  localparam logic [31:0] HASH_Y_MUL = 32'd57;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD   = 32'd789221;
  localparam logic [31:0] HASH_OFS   = 32'd1376312589;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam longint unsigned    PI_Q30  = 64'd3373259426;
  localparam longint unsigned    ONE_U30 = 64'd1073741824;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_OCT_COUNT = 1'b0,
    CFG_PERSIST   = 1'b1
  } cfg_idx_e;

  // One blend table entry: sin^2 of the scaled angle, Q0.30, built at elaboration
  function automatic logic [WT_W-1:0] blend_entry(int k, int bits);
    longint unsigned u, u2, term, s, sq, pr;
    u  = (PI_Q30 * 64'(k)) >> (bits + 1);
    u2 = (u * u) >> 30;
    term = u;
    s    = u;
    for (int n = 1; n <= 7; n++) begin
      pr = (term * u2) >> 30;
      // Taylor term divisor (2n)(2n+1)
      case (n)
        1:       term = pr / 64'd6;
        2:       term = pr / 64'd20;
        3:       term = pr / 64'd42;
        4:       term = pr / 64'd72;
        5:       term = pr / 64'd110;
        6:       term = pr / 64'd156;
        default: term = pr / 64'd210;
      endcase
      if ((n & 1) == 1) begin
        s = (s >= term) ? s - term : 64'd0;
      end else begin
        s = s + term;
      end
    end
    if (s > ONE_U30) begin
      s = ONE_U30;
    end
    sq = (s * s + 64'd536870912) >> 30;
    if (sq > ONE_U30) begin
      sq = ONE_U30;
    end
    return WT_W'(sq);
  endfunction

endpackage

// ===== hdl/fvn_octave.sv =====
// One octave lane: lattice split, corner hash, cosine blend and amplitude weighting.
module fvn_octave import fvn_pkg::*; #(
  parameter int OCT              = 0,
  parameter int FRAC_BITS        = 16,
  parameter int BLEND_TABLE_BITS = 8
) (
  input  logic                    clk_i,
  input  logic [OCT_STAGES-1:0]   en_i,
  input  logic signed [31:0]      x_pos_i,
  input  logic signed [31:0]      y_pos_i,
  input  logic [AMP_W-1:0]        amp_i,
  input  logic                    act_i,
  output logic signed [WGT_W-1:0] wgt_o
);

  localparam int TBL = 1 << BLEND_TABLE_BITS;

  // Blend table, constant
  logic [WT_W-1:0] rom [TBL];
  for (genvar k = 0; k < TBL; k++) begin : g_rom
    localparam logic [WT_W-1:0] ENTRY = blend_entry(k, BLEND_TABLE_BITS);
    assign rom[k] = ENTRY;
  end

  // Split each coordinate into lattice integer and table index
  logic signed [31:0]                      pos [2];
  logic signed [63:0]                      sc  [2];
  logic [FRAC_BITS-1:0]                    lo  [2];
  logic [FRAC_BITS-1:0]                    mag [2];
  logic                                    rnd [2];
  logic [FRAC_BITS+BLEND_TABLE_BITS-1:0]   ext [2];
  logic [31:0]                             ip_d  [2];
  logic [BLEND_TABLE_BITS-1:0]             idx_d [2];

  assign pos[0] = x_pos_i;
  assign pos[1] = y_pos_i;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sc[c]  = 64'(pos[c]) <<< OCT;
      lo[c]  = sc[c][FRAC_BITS-1:0];
      rnd[c] = sc[c][63] && (lo[c] != '0);   // truncate toward zero
      ip_d[c] = 32'(sc[c] >>> FRAC_BITS) + {31'd0, rnd[c]};
      mag[c]  = rnd[c] ? (~lo[c] + 1'b1) : lo[c];
      ext[c]  = {mag[c], {BLEND_TABLE_BITS{1'b0}}};
      idx_d[c] = ext[c][FRAC_BITS +: BLEND_TABLE_BITS];
    end
  end

  // Stage 0: lattice coordinates and indexes
  logic [31:0]                 s0_ip_q  [2];
  logic [BLEND_TABLE_BITS-1:0] s0_idx_q [2];
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_ip_q  <= ip_d;
      s0_idx_q <= idx_d;
    end
  end

  // Stage 1: corner seeds and blend weights
  logic [31:0] seed_d [4];
  logic [31:0] cx, cy;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      cx = s0_ip_q[0] + 32'(j & 1);
      cy = s0_ip_q[1] + 32'(j >> 1);
      seed_d[j] = cx + cy * HASH_Y_MUL;
      seed_d[j] = (seed_d[j] << HASH_SHIFT) ^ seed_d[j];
    end
  end

  logic [31:0]     s1_n_q [4];
  logic [WT_W-1:0] s1_wx_q, s1_wy_q;
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_n_q  <= seed_d;
      s1_wx_q <= rom[s0_idx_q[0]];
      s1_wy_q <= rom[s0_idx_q[1]];
    end
  end

  // Stage 2: n*n
  logic [31:0]     s2_n_q [4];
  logic [31:0]     s2_sq_q [4];
  logic [WT_W-1:0] s2_wx_q, s2_wy_q;
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int j = 0; j < 4; j++) begin
        s2_sq_q[j] <= s1_n_q[j] * s1_n_q[j];
      end
      s2_n_q  <= s1_n_q;
      s2_wx_q <= s1_wx_q;
      s2_wy_q <= s1_wy_q;
    end
  end

  // Stage 3: n*n*15731 + 789221
  logic [31:0]     s3_n_q [4];
  logic [31:0]     s3_t_q [4];
  logic [WT_W-1:0] s3_wx_q, s3_wy_q;
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int j = 0; j < 4; j++) begin
        s3_t_q[j] <= s2_sq_q[j] * HASH_MUL + HASH_ADD;
      end
      s3_n_q  <= s2_n_q;
      s3_wx_q <= s2_wx_q;
      s3_wy_q <= s2_wy_q;
    end
  end

  // Stage 4: final hash and corner value
  logic [31:0]        m_d [4];
  logic signed [31:0] s4_c_q [4];
  logic [WT_W-1:0]    s4_wx_q, s4_wy_q;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      m_d[j] = s3_n_q[j] * s3_t_q[j] + HASH_OFS;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int j = 0; j < 4; j++) begin
        s4_c_q[j] <= ONE_Q30 - $signed({1'b0, m_d[j][30:0]});
      end
      s4_wx_q <= s3_wx_q;
      s4_wy_q <= s3_wy_q;
    end
  end

  // Stage 5: x blend products
  logic signed [32:0] dt_d, db_d;
  logic signed [64:0] s5_pt_q, s5_pb_q;
  logic signed [31:0] s5_a0_q, s5_a2_q;
  logic [WT_W-1:0]    s5_wy_q;
  assign dt_d = 33'(s4_c_q[1]) - 33'(s4_c_q[0]);
  assign db_d = 33'(s4_c_q[3]) - 33'(s4_c_q[2]);
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s5_pt_q <= 65'(dt_d) * 65'($signed({1'b0, s4_wx_q}));
      s5_pb_q <= 65'(db_d) * 65'($signed({1'b0, s4_wx_q}));
      s5_a0_q <= s4_c_q[0];
      s5_a2_q <= s4_c_q[2];
      s5_wy_q <= s4_wy_q;
    end
  end

  // Stage 6: top and bottom edges
  logic signed [33:0] top_d, bot_d;
  logic signed [31:0] s6_top_q, s6_bot_q;
  logic [WT_W-1:0]    s6_wy_q;
  assign top_d = 34'(s5_a0_q) + 34'(s5_pt_q >>> 30);
  assign bot_d = 34'(s5_a2_q) + 34'(s5_pb_q >>> 30);
  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s6_top_q <= top_d[31:0];
      s6_bot_q <= bot_d[31:0];
      s6_wy_q  <= s5_wy_q;
    end
  end

  // Stage 7: y blend product
  logic signed [32:0] dy_d;
  logic signed [64:0] s7_p_q;
  logic signed [31:0] s7_top_q;
  assign dy_d = 33'(s6_bot_q) - 33'(s6_top_q);
  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s7_p_q   <= 65'(dy_d) * 65'($signed({1'b0, s6_wy_q}));
      s7_top_q <= s6_top_q;
    end
  end

  // Stage 8: octave value
  logic signed [33:0] v_d;
  logic signed [31:0] s8_v_q;
  assign v_d = 34'(s7_top_q) + 34'(s7_p_q >>> 30);
  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s8_v_q <= v_d[31:0];
    end
  end

  // Stage 9: amplitude weighting, zero for octaves beyond the count
  logic signed [WGT_W-1:0] s9_w_q;
  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      s9_w_q <= act_i ? WGT_W'(s8_v_q) * WGT_W'($signed({1'b0, amp_i})) : '0;
    end
  end

  assign wgt_o = s9_w_q;

endmodule

// ===== hdl/fvn_div.sv =====
// Pipelined restoring divider: weighted sum over weight total, truncated toward zero.
module fvn_div import fvn_pkg::*; #(
  parameter int TOT_W = 53,
  parameter int WS_W  = 21
) (
  input  logic                    clk_i,
  input  logic [QUO_W+1:0]        en_i,
  input  logic signed [TOT_W-1:0] total_i,
  input  logic [WS_W-1:0]         wsum_i,
  output logic signed [31:0]      quo_o
);

  logic [TOT_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic signed [31:0] out_q;

  // Stage 0: sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      neg_q[0] <= total_i[TOT_W-1];
      rem_q[0] <= total_i[TOT_W-1] ? TOT_W'(-total_i) : TOT_W'(total_i);
      quo_q[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    localparam int B = QUO_W - j;
    logic [TOT_W-1:0] dvs, rdf;
    logic             ge;
    assign dvs = TOT_W'(wsum_i) << B;
    assign ge  = rem_q[j-1] >= dvs;
    assign rdf = rem_q[j-1] - dvs;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        quo_q[j] <= ge ? (quo_q[j-1] | (QUO_W'(1) << B)) : quo_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end
    if (j < QUO_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          rem_q[j] <= ge ? rdf : rem_q[j-1];
        end
      end
    end
  end

  // Output register: restore the sign
  always_ff @(posedge clk_i) begin
    if (en_i[QUO_W+1]) begin
      out_q <= neg_q[QUO_W] ? -$signed({1'b0, quo_q[QUO_W]})
                            :  $signed({1'b0, quo_q[QUO_W]});
    end
  end

  assign quo_o = out_q;

endmodule

// ===== hdl/fractal_value_noise_unit.sv =====
// Pipeline: 10 lane, 2 sum and 33 divider stages from input accept to result valid.
// Throughput: one item per clock while the output is ready and the unit is not settling;
// octave lanes run in parallel, and stages with no item move up while the output waits.
// Reset: clears all stage valid bits and sets octave_count = 6, persistence = 32768.
// in_ready_o stays low after reset and after each register write until a settle counter
// runs out, while the amplitude chain and weight total settle.
module fractal_value_noise_unit import fvn_pkg::*; #(
  parameter int FRAC_BITS        = 16,
  parameter int BLEND_TABLE_BITS = 8,
  parameter int MAX_OCTAVES      = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] x_pos_i,
  input  logic signed [31:0] y_pos_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] noise_value_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i
);

  localparam int OCT_L  = $clog2(MAX_OCTAVES);
  localparam int TOT_W  = WGT_W + OCT_L + 1;
  localparam int WS_W   = AMP_W + OCT_L + 1;
  localparam int NG     = (MAX_OCTAVES + 3) / 4;
  localparam int NST    = OCT_STAGES + 2 + QUO_W + 2;
  localparam int BUSY_W = $clog2(MAX_OCTAVES + 2);
  localparam logic [BUSY_W-1:0] SETTLE = BUSY_W'(MAX_OCTAVES + 1);

  // Configuration registers
  logic [3:0]        octave_count_q;
  logic [AMP_W-1:0]  persistence_q;
  logic [BUSY_W-1:0] busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= 4'd6;
      persistence_q  <= 17'd32768;
      busy_q         <= SETTLE;
    end else if (cfg_we_i) begin
      busy_q <= SETTLE;
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OCT_COUNT: octave_count_q <= cfg_data_i[3:0];
        CFG_PERSIST:   persistence_q  <= cfg_data_i;
        default:       busy_q         <= SETTLE;
      endcase
    end else if (busy_q != '0) begin
      busy_q <= busy_q - 1'b1;
    end
  end

  // Clamped settings
  logic [AMP_W-1:0] pers_eff;
  logic [3:0]       oc_eff;
  logic             act [MAX_OCTAVES];
  assign pers_eff = (persistence_q > AMP_ONE) ? AMP_ONE : persistence_q;
  always_comb begin
    if (octave_count_q == 4'd0) begin
      oc_eff = 4'd1;
    end else if (int'(octave_count_q) > MAX_OCTAVES) begin
      oc_eff = 4'(MAX_OCTAVES);
    end else begin
      oc_eff = octave_count_q;
    end
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      act[i] = int'(oc_eff) > i;
    end
  end

  // Amplitude chain, one multiply per register
  logic [AMP_W-1:0] amp [MAX_OCTAVES];
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_amp
    if (i == 0) begin : g_first
      assign amp[0] = AMP_ONE;
    end else begin : g_next
      logic [AMP_W-1:0] amp_q;
      always_ff @(posedge clk_i) begin
        amp_q <= AMP_W'((34'(amp[i-1]) * 34'(pers_eff)) >> 16);
      end
      assign amp[i] = amp_q;
    end
  end

  // Weight total over active octaves
  logic [WS_W-1:0] wsum_d, wsum_q;
  always_comb begin
    wsum_d = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (act[i]) begin
        wsum_d = wsum_d + WS_W'(amp[i]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    wsum_q <= wsum_d;
  end

  // Stage valid bits and per-stage advance; empty stages fill while later ones hold
  logic [NST-1:0] vld_q;
  logic [NST:0]   en;
  logic           busy;

  assign busy    = busy_q != '0;
  assign en[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i && !busy;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0] && !busy;
  assign out_valid_o = vld_q[NST-1];

  // Octave lanes
  logic signed [WGT_W-1:0] wgt [NG*4];
  for (genvar i = 0; i < NG*4; i++) begin : g_oct
    if (i < MAX_OCTAVES) begin : g_lane
      fvn_octave #(
        .OCT              (i),
        .FRAC_BITS        (FRAC_BITS),
        .BLEND_TABLE_BITS (BLEND_TABLE_BITS)
      ) u_oct (
        .clk_i   (clk_i),
        .en_i    (en[OCT_STAGES-1:0]),
        .x_pos_i (x_pos_i),
        .y_pos_i (y_pos_i),
        .amp_i   (amp[i]),
        .act_i   (act[i]),
        .wgt_o   (wgt[i])
      );
    end else begin : g_pad
      assign wgt[i] = '0;
    end
  end

  // Sum stage A: groups of four lanes
  logic signed [TOT_W-1:0] grp_d [NG];
  logic signed [TOT_W-1:0] grp_q [NG];
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int l = 0; l < 4; l++) begin
        grp_d[g] = grp_d[g] + TOT_W'(wgt[g*4+l]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[OCT_STAGES]) begin
      grp_q <= grp_d;
    end
  end

  // Sum stage B: weighted total
  logic signed [TOT_W-1:0] total_d, total_q;
  always_comb begin
    total_d = '0;
    for (int g = 0; g < NG; g++) begin
      total_d = total_d + grp_q[g];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[OCT_STAGES+1]) begin
      total_q <= total_d;
    end
  end

  // Normalize
  fvn_div #(
    .TOT_W (TOT_W),
    .WS_W  (WS_W)
  ) u_div (
    .clk_i   (clk_i),
    .en_i    (en[OCT_STAGES+2 +: QUO_W+2]),
    .total_i (total_q),
    .wsum_i  (wsum_q),
    .quo_o   (noise_value_o)
  );

endmodule

// ===== verif/fractal_value_noise_unit_test.sv =====
// Self-checking testbench for the fractal value noise unit.
module fractal_value_noise_unit_test;
  import fvn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS        = 16;
  localparam int BLEND_TABLE_BITS = 8;
  localparam int MAX_OCTAVES      = 8;
  localparam int TABLE_SIZE       = 1 << BLEND_TABLE_BITS;
  localparam int LATENCY          = 45;
  localparam longint CYCLE_LIMIT  = 1_500_000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] x_pos_i;
  logic signed [31:0] y_pos_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] noise_value_o;
  logic               cfg_we_i;
  logic [0:0]         cfg_index_i;
  logic [16:0]        cfg_data_i;

  fractal_value_noise_unit #(
    .FRAC_BITS(FRAC_BITS),
    .BLEND_TABLE_BITS(BLEND_TABLE_BITS),
    .MAX_OCTAVES(MAX_OCTAVES)
  ) dut (.*);

  // Predictor state
  longint            cos_weight[TABLE_SIZE];
  logic [3:0]        octaves_reg;
  logic [16:0]       persist_reg;
  logic signed [31:0] noise_queue[$];
  int                error_count;
  int                result_count;
  int                item_count;
  longint            cycle_count;
  bit                stall_hold;
  bit                rx_quiet;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Blend table, sin^2 of the scaled angle in Q0.30
  function automatic void build_weights();
    longint unsigned u, u2, term, s, sq;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      u = (PI_Q30 * longint'(k)) >> (BLEND_TABLE_BITS + 1);
      u2 = (u * u) >> 30;
      term = u;
      s = u;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * u2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = (s >= term) ? s - term : 0;
        else s = s + term;
      end
      if (s > ONE_U30) s = ONE_U30;
      sq = (s * s + 64'd536870912) >> 30;
      if (sq > ONE_U30) sq = ONE_U30;
      cos_weight[k] = longint'(sq);
    end
  endfunction

  function automatic longint floor_shift30(longint v);
    return v >>> 30;
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + floor_shift30((b - a) * w);
  endfunction

  function automatic longint lattice_value(logic [31:0] ix, logic [31:0] iy);
    logic [31:0] n, m;
    n = ix + iy * 32'd57;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
    return 64'sd1073741824 - longint'({32'd0, m});
  endfunction

  function automatic longint weight_of(longint frac);
    longint a;
    a = (frac < 0) ? -frac : frac;
    return cos_weight[(a >> (FRAC_BITS - BLEND_TABLE_BITS)) & (TABLE_SIZE - 1)];
  endfunction

  // Expected noise for one point under the current settings
  function automatic logic signed [31:0] fractal_noise(logic signed [31:0] xp,
                                                       logic signed [31:0] yp);
    longint x, y, p, amp, total, wsum, sx, sy, wx_i, wy_i, fx, fy, wx, wy, top, bot;
    logic [31:0] ix, iy;
    int oc;
    x = longint'(xp);
    y = longint'(yp);
    oc = octaves_reg;
    p = (persist_reg > 17'd65536) ? 65536 : longint'(persist_reg);
    amp = 65536;
    total = 0;
    wsum = 0;
    if (oc < 1) oc = 1;
    if (oc > MAX_OCTAVES) oc = MAX_OCTAVES;
    for (int i = 0; i < oc; i++) begin
      sx = x * (longint'(1) << i);
      sy = y * (longint'(1) << i);
      wx_i = sx / 65536;
      wy_i = sy / 65536;
      fx = sx - wx_i * 65536;
      fy = sy - wy_i * 65536;
      ix = wx_i[31:0];
      iy = wy_i[31:0];
      wx = weight_of(fx);
      wy = weight_of(fy);
      top = mix(lattice_value(ix, iy), lattice_value(ix + 1, iy), wx);
      bot = mix(lattice_value(ix, iy + 1), lattice_value(ix + 1, iy + 1), wx);
      total += mix(top, bot, wy) * amp;
      wsum += amp;
      amp = (amp * p) >>> 16;
    end
    return 32'(total / wsum);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Random gap, mostly short with a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one point; valid stays up for a back-to-back follower
  task automatic send_point(logic signed [31:0] xp, logic signed [31:0] yp, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_pos_i    <= xp;
    y_pos_i    <= yp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    noise_queue = {noise_queue, fractal_noise(xp, yp)};
    item_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (noise_queue.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  // Register write while idle
  task automatic write_reg(cfg_idx_e idx, logic [16:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OCT_COUNT) octaves_reg = value[3:0];
    else persist_reg = value;
  endtask

  function automatic logic signed [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed(32'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    if (r < 7) return $signed($urandom());
    if (r < 8) return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
    return {16'($urandom()), 16'h0000};
  endfunction

  task automatic test_directed();
    logic signed [31:0] pts[$];
    pts = '{32'sh0000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_ffff,
            32'shffff_0001, 32'sh0000_8000, 32'shffff_8000, 32'sh0001_0000,
            32'shffff_ffff, 32'sh7fff_0000, 32'sh8000_0001, 32'sh5555_aaaa};
    foreach (pts[i]) send_point(pts[i], pts[pts.size() - 1 - i], 1'b0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'shaaaa_5555, 32'sh0000_0001, 1'b0);
  endtask

  // Octave count and persistence sweep, extremes and out-of-range codes
  task automatic test_settings();
    logic [3:0]  octs[$];
    logic [16:0] pers[$];
    octs = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9, 4'd3};
    pers = '{17'd0, 17'd65536, 17'h1ffff, 17'd65537, 17'd40000, 17'd1};
    foreach (octs[i]) begin
      write_reg(CFG_OCT_COUNT, 17'(octs[i]));
      write_reg(CFG_PERSIST, pers[i]);
      repeat (60) send_point(rand_coord(), rand_coord(), 1'b1);
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_OCT_COUNT, 17'($urandom_range(0, 15)));
      write_reg(CFG_PERSIST, 17'($urandom_range(0, 17'h1ffff)));
      repeat (140) send_point(rand_coord(), rand_coord(), phase % 3 != 2);
    end
  endtask

  // Receiver holds off while items keep coming, then sender drains fully and sends more
  task automatic test_backpressure();
    write_reg(CFG_OCT_COUNT, 17'd8);
    write_reg(CFG_PERSIST, 17'd65536);
    stall_hold = 1'b1;
    repeat (100) send_point(rand_coord(), rand_coord(), 1'b0);
    stall_hold = 1'b0;
    wait_drained();
    repeat (40) send_point(rand_coord(), rand_coord(), 1'b0);
  endtask

  // Receiver readiness; a hold-off request is served once for a counted stretch
  initial begin
    int g;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_hold) begin
        out_ready_i <= 1'b0;
        for (int c = 0; c < 150; c++) @(negedge clk_i);
        stall_hold = 1'b0;
      end
      g = rx_quiet ? 0 : pick_gap();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker
  initial begin
    logic signed [31:0] want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        result_count++;
        if (noise_queue.size() == 0) begin
          report_mismatch("unexpected noise_value", noise_value_o, 0);
        end else begin
          want = noise_queue.pop_front();
          if (noise_value_o !== want) report_mismatch("noise_value", noise_value_o, want);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    result_count = 0;
    item_count = 0;
    stall_hold = 1'b0;
    rx_quiet = 1'b0;
    in_valid_i = 1'b0;
    x_pos_i = '0;
    y_pos_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_OCT_COUNT;
    cfg_data_i = '0;
    octaves_reg = 4'd6;
    persist_reg = 17'd32768;
    build_weights();
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    rx_quiet = 1'b1;
    test_settings();
    rx_quiet = 1'b0;
    test_random();
    test_backpressure();
    wait_drained();
    if (noise_queue.size() != 0) report_mismatch("results left over", noise_queue.size(), 0);
    $display("Ran %0d points, %0d results checked, octave counts 0..15 and persistence",
             item_count, result_count);
    $display("from zero to above one, with random stalls and a long output hold-off.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
